[sv/ehi_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the extendible hash index
// no dependencies

package ehi_pkg;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    localparam int KEY_COUNT_W    = 12;
    localparam int BUCKET_COUNT_W = 9;
    localparam int DEPTH_W        = 4;

    typedef logic [63:0] word_t;

endpackage

[sv/ehi_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one read port, registered read
// no dependencies

module ehi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/extendible_hash_index.sv]
`timescale 1ns / 1ps
// extendible hash index: insert, search and delete of fixed-width keys
// depends on ehi_pkg and ehi_ram
// an accepted beat is hashed one fnv-1a round per key byte, then the directory and bucket
//   metadata are read and each filled slot is compared in turn; a delete shifts later slots
//   down; a split doubles the directory if needed, updates it, moves each slot to the old or
//   new bucket, writes both metadata words and then looks up again from the directory read
// one item at a time: no new beat is taken until the last result is in the output register
// reset: a clearing pass over max(2^TOP_DEPTH, buckets) entries fills the directory
//   and bucket table; no item is accepted until it ends

module extendible_hash_index #(
    parameter int KEY_BYTES     = 8,
    parameter int BUCKET_SLOTS  = 8,
    parameter int MAX_DEPTH     = 8,
    parameter int INITIAL_DEPTH = 2,
    parameter int MAX_BUCKETS   = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // key_word, value_in
    input  logic [1:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata   // status, value_out, key_count, bucket_count, depth_now
);

    localparam int TOP_DEPTH = (MAX_DEPTH > INITIAL_DEPTH) ? MAX_DEPTH : INITIAL_DEPTH;
    localparam int DIR_SIZE  = 1 << TOP_DEPTH;
    localparam int INIT_BK   = 1 << INITIAL_DEPTH;
    localparam int NBUCK     = (MAX_BUCKETS > INIT_BK) ? MAX_BUCKETS : INIT_BK;
    localparam int NSLOT     = NBUCK * BUCKET_SLOTS;
    localparam int DIR_AW    = TOP_DEPTH;
    localparam int BW        = $clog2(NBUCK);
    localparam int UW        = $clog2(NBUCK + 1);
    localparam int FW        = $clog2(BUCKET_SLOTS + 1);
    localparam int SAW       = $clog2(NSLOT);
    localparam int KW        = $clog2(NSLOT + 1);
    localparam int HCW       = $clog2(KEY_BYTES + 1);
    localparam int TRIES     = TOP_DEPTH + 2;
    localparam int TW        = $clog2(TRIES + 1);
    localparam int CLR_N     = (DIR_SIZE > NBUCK) ? DIR_SIZE : NBUCK;
    localparam int CW        = $clog2(CLR_N);
    localparam int MW        = 4 + FW;
    localparam int SLW       = 160;
    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);

    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_HASH    = 5'd2;
    localparam logic [4:0] S_DIR     = 5'd3;
    localparam logic [4:0] S_META    = 5'd4;
    localparam logic [4:0] S_SCAN0   = 5'd5;
    localparam logic [4:0] S_SCAN    = 5'd6;
    localparam logic [4:0] S_CMP     = 5'd7;
    localparam logic [4:0] S_DEL     = 5'd8;
    localparam logic [4:0] S_DEL_WR  = 5'd9;
    localparam logic [4:0] S_SPLIT   = 5'd10;
    localparam logic [4:0] S_DBL_RD  = 5'd11;
    localparam logic [4:0] S_DBL_WR  = 5'd12;
    localparam logic [4:0] S_ALLOC   = 5'd13;
    localparam logic [4:0] S_DIRUP   = 5'd14;
    localparam logic [4:0] S_MV_RD   = 5'd15;
    localparam logic [4:0] S_MV_WR   = 5'd16;
    localparam logic [4:0] S_MV_META = 5'd17;
    localparam logic [4:0] S_DONE    = 5'd18;

    function automatic logic [SAW-1:0] slot_addr(input logic [BW-1:0] bk,
                                                 input logic [FW-1:0] sl);
        return SAW'(bk) * SAW'(BUCKET_SLOTS) + SAW'(sl);
    endfunction

    logic [4:0]          state_reg, state_next;
    logic [CW-1:0]       clr_reg, clr_next;
    logic [1:0]          mode_reg, mode_next;
    ehi_pkg::word_t      key_reg, key_next;
    ehi_pkg::word_t      val_reg, val_next;
    logic [31:0]         h_reg, h_next;
    logic [HCW-1:0]      cnt_reg, cnt_next;
    logic [DIR_AW-1:0]   idx_reg, idx_next;
    logic [BW-1:0]       b_reg, b_next;
    logic [BW-1:0]       nb_reg, nb_next;
    logic [3:0]          depth_reg, depth_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [FW-1:0]       s_reg, s_next;
    logic [FW-1:0]       keep_reg, keep_next;
    logic [FW-1:0]       moved_reg, moved_next;
    logic [DIR_AW:0]     i_reg, i_next;
    logic [TW-1:0]       tries_reg, tries_next;
    logic [3:0]          gd_reg, gd_next;
    logic [UW-1:0]       used_reg, used_next;
    logic [KW-1:0]       keys_reg, keys_next;
    logic [1:0]          status_reg, status_next;
    ehi_pkg::word_t      vout_reg, vout_next;
    logic                out_valid_reg, out_valid_next;
    logic [95:0]         out_data_reg, out_data_next;

    logic                dir_we;
    logic [DIR_AW-1:0]   dir_waddr, dir_raddr;
    logic [BW-1:0]       dir_wdata, dir_rdata;
    logic                meta_we;
    logic [BW-1:0]       meta_waddr, meta_raddr;
    logic [MW-1:0]       meta_wdata, meta_rdata;
    logic                slot_we;
    logic [SAW-1:0]      slot_waddr, slot_raddr;
    logic [SLW-1:0]      slot_wdata, slot_rdata;

    logic [7:0]          key_byte;
    logic [31:0]         hash_step;
    logic [DIR_AW-1:0]   dir_idx;
    logic [DIR_AW:0]     dir_span;
    logic [DIR_AW-1:0]   low_mask;
    logic [DIR_AW-1:0]   i_shift;
    logic [31:0]         rd_hash_shift;
    logic                slot_match;

    ehi_ram #(.WIDTH(BW), .DEPTH(DIR_SIZE)) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    ehi_ram #(.WIDTH(MW), .DEPTH(NBUCK)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    ehi_ram #(.WIDTH(SLW), .DEPTH(NSLOT)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // one fnv-1a round per cycle
    assign key_byte  = 8'(key_reg >> {cnt_reg, 3'b000});
    assign hash_step = 32'((h_reg ^ {24'd0, key_byte}) * ehi_pkg::FNV_PRIME);

    assign dir_idx  = h_reg[DIR_AW-1:0] & ~({DIR_AW{1'b1}} << gd_reg);
    assign dir_span = (DIR_AW + 1)'(1) << gd_reg;
    // depth_reg already holds the new local depth during the directory update
    assign low_mask = ~({DIR_AW{1'b1}} << (depth_reg - 4'd1));
    assign i_shift  = i_reg[DIR_AW-1:0] >> (depth_reg - 4'd1);
    assign rd_hash_shift = slot_rdata[31:0] >> (depth_reg - 4'd1);
    assign slot_match = (slot_rdata[31:0] == h_reg) && (slot_rdata[95:32] == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        h_next         = h_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        b_next         = b_reg;
        nb_next        = nb_reg;
        depth_next     = depth_reg;
        fill_next      = fill_reg;
        s_next         = s_reg;
        keep_next      = keep_reg;
        moved_next     = moved_reg;
        i_next         = i_reg;
        tries_next     = tries_reg;
        gd_next        = gd_reg;
        used_next      = used_reg;
        keys_next      = keys_reg;
        status_next    = status_reg;
        vout_next      = vout_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        dir_we     = 1'b0;
        dir_waddr  = i_reg[DIR_AW-1:0];
        dir_wdata  = nb_reg;
        dir_raddr  = dir_idx;
        meta_we    = 1'b0;
        meta_waddr = b_reg;
        meta_wdata = {fill_reg, depth_reg};
        meta_raddr = b_reg;
        slot_we    = 1'b0;
        slot_waddr = slot_addr(b_reg, s_reg);
        slot_wdata = {val_reg, key_reg, h_reg};
        slot_raddr = slot_addr(b_reg, s_reg);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                dir_waddr  = DIR_AW'(clr_reg);
                dir_wdata  = ({1'b0, clr_reg} < (CW + 1)'(INIT_BK)) ? BW'(clr_reg) : '0;
                dir_we     = ({1'b0, clr_reg} < (CW + 1)'(DIR_SIZE));
                meta_waddr = BW'(clr_reg);
                meta_wdata = {FW'(0), 4'(INITIAL_DEPTH)};
                meta_we    = ({1'b0, clr_reg} < (CW + 1)'(NBUCK));
                if (clr_reg == CW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mode_next  = s_axis_tuser;
                    key_next   = s_axis_tdata[63:0] & KEY_MASK;
                    val_next   = s_axis_tdata[127:64];
                    h_next     = ehi_pkg::FNV_BASIS;
                    cnt_next   = '0;
                    tries_next = '0;
                    vout_next  = '0;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                h_next   = hash_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == HCW'(KEY_BYTES - 1))
                begin
                    if (mode_reg == ehi_pkg::MODE_INSERT || mode_reg == ehi_pkg::MODE_SEARCH
                        || mode_reg == ehi_pkg::MODE_DELETE)
                    begin
                        state_next = S_DIR;
                    end
                    else
                    begin
                        status_next = ehi_pkg::STATUS_MISS;
                        state_next  = S_DONE;
                    end
                end
            end
            S_DIR:
            begin
                dir_raddr  = dir_idx;
                idx_next   = dir_idx;
                state_next = S_META;
            end
            S_META:
            begin
                b_next     = dir_rdata;
                meta_raddr = dir_rdata;
                state_next = S_SCAN0;
            end
            S_SCAN0:
            begin
                depth_next = meta_rdata[3:0];
                fill_next  = meta_rdata[MW-1:4];
                s_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                slot_raddr = slot_addr(b_reg, s_reg);
                if (s_reg < fill_reg)
                begin
                    state_next = S_CMP;
                end
                else if (mode_reg != ehi_pkg::MODE_INSERT)
                begin
                    status_next = ehi_pkg::STATUS_MISS;
                    state_next  = S_DONE;
                end
                else if (fill_reg < FW'(BUCKET_SLOTS))
                begin
                    slot_we     = 1'b1;
                    slot_waddr  = slot_addr(b_reg, fill_reg);
                    meta_we     = 1'b1;
                    meta_wdata  = {fill_reg + 1'b1, depth_reg};
                    keys_next   = keys_reg + 1'b1;
                    status_next = ehi_pkg::STATUS_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_CMP:
            begin
                if (slot_match)
                begin
                    status_next = ehi_pkg::STATUS_OK;
                    if (mode_reg == ehi_pkg::MODE_SEARCH)
                    begin
                        vout_next  = slot_rdata[159:96];
                        state_next = S_DONE;
                    end
                    else if (mode_reg == ehi_pkg::MODE_INSERT)
                    begin
                        slot_we    = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DEL;
                    end
                end
                else
                begin
                    s_next     = s_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_DEL:
            begin
                // shift later slots down by one
                slot_raddr = slot_addr(b_reg, s_reg + 1'b1);
                if ((s_reg + 1'b1) < fill_reg)
                begin
                    state_next = S_DEL_WR;
                end
                else
                begin
                    meta_we    = 1'b1;
                    meta_wdata = {fill_reg - 1'b1, depth_reg};
                    keys_next  = keys_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DEL_WR:
            begin
                slot_we    = 1'b1;
                slot_wdata = slot_rdata;
                s_next     = s_reg + 1'b1;
                state_next = S_DEL;
            end
            S_SPLIT:
            begin
                if (depth_reg >= gd_reg)
                begin
                    if (gd_reg >= 4'(MAX_DEPTH))
                    begin
                        status_next = ehi_pkg::STATUS_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        i_next     = '0;
                        state_next = S_DBL_RD;
                    end
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_DBL_RD:
            begin
                dir_raddr = i_reg[DIR_AW-1:0];
                if (i_reg < dir_span)
                begin
                    state_next = S_DBL_WR;
                end
                else
                begin
                    gd_next    = gd_reg + 1'b1;
                    state_next = S_ALLOC;
                end
            end
            S_DBL_WR:
            begin
                dir_we     = 1'b1;
                dir_waddr  = DIR_AW'(i_reg + dir_span);
                dir_wdata  = dir_rdata;
                i_next     = i_reg + 1'b1;
                state_next = S_DBL_RD;
            end
            S_ALLOC:
            begin
                if (used_reg >= UW'(MAX_BUCKETS))
                begin
                    status_next = ehi_pkg::STATUS_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    nb_next    = BW'(used_reg);
                    used_next  = used_reg + 1'b1;
                    depth_next = depth_reg + 1'b1;
                    i_next     = '0;
                    state_next = S_DIRUP;
                end
            end
            S_DIRUP:
            begin
                if (i_reg < dir_span)
                begin
                    // entries sharing the low bits with the new bit set move to the new bucket
                    dir_we = (((i_reg[DIR_AW-1:0] ^ idx_reg) & low_mask) == '0) && i_shift[0];
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    s_next     = '0;
                    keep_next  = '0;
                    moved_next = '0;
                    state_next = S_MV_RD;
                end
            end
            S_MV_RD:
            begin
                slot_raddr = slot_addr(b_reg, s_reg);
                if (s_reg < fill_reg)
                begin
                    state_next = S_MV_WR;
                end
                else
                begin
                    meta_we    = 1'b1;
                    meta_wdata = {keep_reg, depth_reg};
                    state_next = S_MV_META;
                end
            end
            S_MV_WR:
            begin
                slot_we    = 1'b1;
                slot_wdata = slot_rdata;
                if (rd_hash_shift[0])
                begin
                    slot_waddr = slot_addr(nb_reg, moved_reg);
                    moved_next = moved_reg + 1'b1;
                end
                else
                begin
                    slot_waddr = slot_addr(b_reg, keep_reg);
                    keep_next  = keep_reg + 1'b1;
                end
                s_next     = s_reg + 1'b1;
                state_next = S_MV_RD;
            end
            S_MV_META:
            begin
                meta_we    = 1'b1;
                meta_waddr = nb_reg;
                meta_wdata = {moved_reg, depth_reg};
                tries_next = tries_reg + 1'b1;
                if (tries_reg == TW'(TRIES - 1))
                begin
                    status_next = ehi_pkg::STATUS_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_DIR;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'd0,
                                      ehi_pkg::DEPTH_W'(gd_reg),
                                      ehi_pkg::BUCKET_COUNT_W'(used_reg),
                                      ehi_pkg::KEY_COUNT_W'(keys_reg),
                                      vout_reg,
                                      status_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            gd_reg        <= 4'(INITIAL_DEPTH);
            used_reg      <= UW'(INIT_BK);
            keys_reg      <= '0;
            out_valid_reg <= 1'b0;
            tries_reg     <= '0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            s_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            gd_reg        <= gd_next;
            used_reg      <= used_next;
            keys_reg      <= keys_next;
            out_valid_reg <= out_valid_next;
            tries_reg     <= tries_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            s_reg         <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        h_reg        <= h_next;
        idx_reg      <= idx_next;
        b_reg        <= b_next;
        nb_reg       <= nb_next;
        depth_reg    <= depth_next;
        fill_reg     <= fill_next;
        keep_reg     <= keep_next;
        moved_reg    <= moved_next;
        status_reg   <= status_next;
        vout_reg     <= vout_next;
        out_data_reg <= out_data_next;
    end

    a_accept_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == S_HASH)
        else $error("accepted beat did not start hashing");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gd_reg <= 4'(TOP_DEPTH))
        else $error("global depth beyond directory size");

    a_keys_bound: assert property (@(posedge clk) disable iff (!rst_n)
        keys_reg <= KW'(NSLOT))
        else $error("key count beyond slot capacity");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(NBUCK))
        else $error("bucket count beyond bucket table");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for extendible_hash_index: random and directed insert/search/delete
// depends on ehi_pkg and the extendible_hash_index rtl

module tb_top;

    localparam int KEY_BYTES     = 8;
    localparam int BUCKET_SLOTS  = 8;
    localparam int MAX_DEPTH     = 8;
    localparam int INITIAL_DEPTH = 2;
    localparam int MAX_BUCKETS   = 256;
    localparam int TOP_DEPTH     = (MAX_DEPTH > INITIAL_DEPTH) ? MAX_DEPTH : INITIAL_DEPTH;
    localparam int DIR_SIZE      = 1 << TOP_DEPTH;
    localparam int INIT_BUCKETS  = 1 << INITIAL_DEPTH;
    localparam int NBUCK         = (MAX_BUCKETS > INIT_BUCKETS) ? MAX_BUCKETS : INIT_BUCKETS;
    localparam int NSLOT         = NBUCK * BUCKET_SLOTS;
    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - 8 * KEY_BYTES);
    // mode code with no operation behind it
    localparam logic [ehi_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [ehi_pkg::MODE_W-1:0] mode;
        ehi_pkg::word_t             key;
        ehi_pkg::word_t             value;
    } op_t;

    typedef struct packed {
        logic [ehi_pkg::STATUS_W-1:0]       status;
        ehi_pkg::word_t                     value;
        logic [ehi_pkg::KEY_COUNT_W-1:0]    keys;
        logic [ehi_pkg::BUCKET_COUNT_W-1:0] buckets;
        logic [ehi_pkg::DEPTH_W-1:0]        depth;
    } reply_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // key_word, value_in
    logic [1:0]   s_axis_tuser;   // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;   // status, value_out, key_count, bucket_count, depth_now

    extendible_hash_index uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // table image kept by the bench
    int    gdepth;
    int    dir_bkt [DIR_SIZE];
    int    bkt_depth [NBUCK];
    int    bkt_fill [NBUCK];
    int    bkts_used;
    int    keys_held;
    logic [31:0]    slot_h [NSLOT];
    ehi_pkg::word_t slot_k [NSLOT];
    ehi_pkg::word_t slot_v [NSLOT];

    op_t    ops_pending[$];
    reply_t replies_due[$];
    op_t    cur_op;
    int     errors;
    int     ops_taken;
    int     replies_seen;
    int     send_gap;
    int     recv_hold;
    bit     long_hold_done;

    function automatic logic [31:0] fnv1a(ehi_pkg::word_t key);
        logic [31:0] h;
        h = ehi_pkg::FNV_BASIS;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            h = h ^ {24'd0, key[8*i +: 8]};
            h = h * ehi_pkg::FNV_PRIME;
        end
        return h;
    endfunction

    function automatic int find_slot(int b, logic [31:0] h, ehi_pkg::word_t key);
        for (int s = 0; s < bkt_fill[b]; s++)
            if (slot_h[b*BUCKET_SLOTS+s] == h && slot_k[b*BUCKET_SLOTS+s] == key)
                return s;
        return -1;
    endfunction

    function automatic bit divide_bucket(int idx);
        int b, nb, ld, low_mask, new_bit, size, keep, moved, p, q;
        b = dir_bkt[idx];
        if (bkt_depth[b] >= gdepth)
        begin
            if (gdepth >= MAX_DEPTH)
                return 0;
            size = 1 << gdepth;
            for (int i = 0; i < size; i++)
                dir_bkt[i+size] = dir_bkt[i];
            gdepth++;
        end
        if (bkts_used >= MAX_BUCKETS)
            return 0;
        nb = bkts_used;
        bkts_used++;
        ld = bkt_depth[b] + 1;
        bkt_depth[b] = ld;
        bkt_depth[nb] = ld;
        low_mask = (1 << (ld - 1)) - 1;
        new_bit = 1 << (ld - 1);
        size = 1 << gdepth;
        for (int i = 0; i < size; i++)
            if ((i & low_mask) == (idx & low_mask) && (i & new_bit) != 0)
                dir_bkt[i] = nb;
        keep = 0;
        moved = 0;
        for (int s = 0; s < bkt_fill[b]; s++)
        begin
            p = b*BUCKET_SLOTS + s;
            if ((slot_h[p] & new_bit) != 0)
            begin
                q = nb*BUCKET_SLOTS + moved;
                moved++;
            end
            else
            begin
                q = b*BUCKET_SLOTS + keep;
                keep++;
            end
            slot_h[q] = slot_h[p];
            slot_k[q] = slot_k[p];
            slot_v[q] = slot_v[p];
        end
        bkt_fill[b] = keep;
        bkt_fill[nb] = moved;
        return 1;
    endfunction

    function automatic logic [ehi_pkg::STATUS_W-1:0] insert_key(logic [31:0] h,
                                                                ehi_pkg::word_t key,
                                                                ehi_pkg::word_t val);
        int idx, b, s, p;
        for (int tries = 0; tries < TOP_DEPTH + 2; tries++)
        begin
            idx = h & ((1 << gdepth) - 1);
            b = dir_bkt[idx];
            s = find_slot(b, h, key);
            if (s >= 0)
            begin
                slot_v[b*BUCKET_SLOTS+s] = val;
                return ehi_pkg::STATUS_OK;
            end
            if (bkt_fill[b] < BUCKET_SLOTS)
            begin
                p = b*BUCKET_SLOTS + bkt_fill[b];
                slot_h[p] = h;
                slot_k[p] = key;
                slot_v[p] = val;
                bkt_fill[b]++;
                keys_held++;
                return ehi_pkg::STATUS_OK;
            end
            if (!divide_bucket(idx))
                return ehi_pkg::STATUS_FULL;
        end
        return ehi_pkg::STATUS_FULL;
    endfunction

    // apply one operation to the table image and queue the reply it should give
    function automatic void apply_op(op_t op);
        ehi_pkg::word_t key;
        logic [31:0]    h;
        int             b, s, base;
        reply_t         r;
        key = op.key & KEY_MASK;
        h = fnv1a(key);
        r.status = ehi_pkg::STATUS_MISS;
        r.value = '0;
        b = dir_bkt[h & ((1 << gdepth) - 1)];
        if (op.mode == ehi_pkg::MODE_INSERT)
        begin
            r.status = insert_key(h, key, op.value);
        end
        else if (op.mode == ehi_pkg::MODE_SEARCH)
        begin
            s = find_slot(b, h, key);
            if (s >= 0)
            begin
                r.status = ehi_pkg::STATUS_OK;
                r.value = slot_v[b*BUCKET_SLOTS+s];
            end
        end
        else if (op.mode == ehi_pkg::MODE_DELETE)
        begin
            s = find_slot(b, h, key);
            if (s >= 0)
            begin
                base = b*BUCKET_SLOTS;
                for (int j = s; j + 1 < bkt_fill[b]; j++)
                begin
                    slot_h[base+j] = slot_h[base+j+1];
                    slot_k[base+j] = slot_k[base+j+1];
                    slot_v[base+j] = slot_v[base+j+1];
                end
                bkt_fill[b]--;
                keys_held--;
                r.status = ehi_pkg::STATUS_OK;
            end
        end
        r.keys = keys_held[ehi_pkg::KEY_COUNT_W-1:0];
        r.buckets = bkts_used[ehi_pkg::BUCKET_COUNT_W-1:0];
        r.depth = gdepth[ehi_pkg::DEPTH_W-1:0];
        replies_due.push_back(r);
    endfunction

    function automatic void check_field(string name, ehi_pkg::word_t exp_v,
                                        ehi_pkg::word_t act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic op_t mk(logic [ehi_pkg::MODE_W-1:0] m, ehi_pkg::word_t k,
                               ehi_pkg::word_t v);
        op_t o;
        o.mode = m;
        o.key = k;
        o.value = v;
        return o;
    endfunction

    function automatic ehi_pkg::word_t rnd64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // stimulus
    initial
    begin
        ehi_pkg::word_t pool[$];
        ehi_pkg::word_t k;
        int             r;
        gdepth = INITIAL_DEPTH;
        for (int i = 0; i < DIR_SIZE; i++)
            dir_bkt[i] = (i < INIT_BUCKETS) ? i : 0;
        for (int i = 0; i < NBUCK; i++)
        begin
            bkt_depth[i] = INITIAL_DEPTH;
            bkt_fill[i] = 0;
        end
        bkts_used = INIT_BUCKETS;
        keys_held = 0;
        errors = 0;

        // directed: field extremes, every mode, update, misses, unused mode
        ops_pending.push_back(mk(ehi_pkg::MODE_INSERT, '0, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_INSERT, '1, '1));
        ops_pending.push_back(mk(ehi_pkg::MODE_INSERT, 64'h0123456789abcdef,
                                 64'hdeadbeefcafef00d));
        ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, '0, '1));
        ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, '1, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, 64'h0123456789abcdef, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_INSERT, '1, 64'h5555aaaa5555aaaa));
        ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, '1, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, 64'h8000000000000001, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_DELETE, 64'h0123456789abcdef, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_DELETE, 64'h0123456789abcdef, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, 64'h0123456789abcdef, '0));
        ops_pending.push_back(mk(MODE_UNUSED, '1, '1));
        ops_pending.push_back(mk(MODE_UNUSED, 64'h00ff00ff00ff00ff, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_INSERT, 64'hff00000000000000,
                                 64'haaaa5555aaaa5555));
        ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, 64'hff00000000000000, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, 64'h00000000000000ff, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_DELETE, '0, '0));
        ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, '0, '0));
        pool.push_back('1);
        pool.push_back(64'hff00000000000000);

        // fill phase is mostly inserts of new keys, driving the table toward depth and bucket exhaustion
        for (int i = 0; i < 1300; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80 || pool.size() == 0)
            begin
                k = rnd64();
                pool.push_back(k);
                ops_pending.push_back(mk(ehi_pkg::MODE_INSERT, k, rnd64()));
            end
            else if (r < 88)
            begin
                ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH,
                    pool[$urandom_range(0, pool.size()-1)], rnd64()));
            end
            else if (r < 96)
            begin
                ops_pending.push_back(mk(ehi_pkg::MODE_DELETE,
                    pool[$urandom_range(0, pool.size()-1)], rnd64()));
            end
            else if (r < 98)
            begin
                ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, rnd64(), rnd64()));
            end
            else
            begin
                ops_pending.push_back(mk(MODE_UNUSED, rnd64(), rnd64()));
            end
        end
        // mixed phase, mostly over known keys: deletes free room, reinserts and updates fill it
        for (int i = 0; i < 500; i++)
        begin
            r = $urandom_range(0, 99);
            k = (r % 5 == 0) ? rnd64() : pool[$urandom_range(0, pool.size()-1)];
            if (r < 35)
                ops_pending.push_back(mk(ehi_pkg::MODE_DELETE, k, rnd64()));
            else if (r < 65)
                ops_pending.push_back(mk(ehi_pkg::MODE_SEARCH, k, rnd64()));
            else if (r < 97)
                ops_pending.push_back(mk(ehi_pkg::MODE_INSERT, k, rnd64()));
            else
                ops_pending.push_back(mk(MODE_UNUSED, k, rnd64()));
        end

        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;

        while (ops_pending.size() != 0 || s_axis_tvalid || replies_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (1200) @(posedge clk);
        if (errors == 0 && replies_due.size() == 0 && !m_axis_tvalid)
            $display("extendible_hash_index regression: pass");
        else
            $display("extendible_hash_index regression: fail");
        $finish;
    end

    initial
    begin
        #80_000_000;
        $display("extendible_hash_index regression: fail");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            s_axis_tvalid <= 0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            send_gap <= 0;
            ops_taken <= 0;
        end
        else
        begin
            gap = send_gap;
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_op(cur_op);
                ops_taken <= ops_taken + 1;
                // every third block of 64 items goes back to back
                gap = ((ops_taken / 64) % 3 == 1) ? 0 : $urandom_range(0, 6);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap == 0 && ops_pending.size() > 0)
                begin
                    cur_op = ops_pending.pop_front();
                    s_axis_tdata <= {cur_op.value, cur_op.key};
                    s_axis_tuser <= cur_op.mode;
                    s_axis_tvalid <= 1;
                end
                else
                begin
                    s_axis_tvalid <= 0;
                    if (gap > 0)
                        gap--;
                end
            end
            send_gap <= gap;
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        int     hold;
        reply_t got, exp_r;
        if (!rst_n)
        begin
            m_axis_tready <= 0;
            recv_hold <= 0;
            replies_seen <= 0;
            long_hold_done <= 0;
        end
        else
        begin
            hold = recv_hold;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status  = m_axis_tdata[1:0];
                got.value   = m_axis_tdata[65:2];
                got.keys    = m_axis_tdata[77:66];
                got.buckets = m_axis_tdata[86:78];
                got.depth   = m_axis_tdata[90:87];
                if (replies_due.size() == 0)
                begin
                    $display("%0t unexpected beat: expected none actual %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_r = replies_due.pop_front();
                    check_field("status", exp_r.status, got.status);
                    check_field("value_out", exp_r.value, got.value);
                    check_field("key_count", exp_r.keys, got.keys);
                    check_field("bucket_count", exp_r.buckets, got.buckets);
                    check_field("depth_now", exp_r.depth, got.depth);
                end
                replies_seen <= replies_seen + 1;
                hold = ((replies_seen / 64) % 3 == 2) ? 0 : $urandom_range(0, 6);
                // one long hold-off so the block backs up onto its input
                if (replies_seen == 300 && !long_hold_done)
                begin
                    hold = 500;
                    long_hold_done <= 1;
                end
            end
            else if (hold > 0)
            begin
                hold--;
            end
            m_axis_tready <= (hold == 0);
            recv_hold <= hold;
        end
    end

endmodule

[sim.f]
sv/ehi_pkg.sv
sv/ehi_ram.sv
sv/extendible_hash_index.sv
sim/tb_top.sv
